### rtl/rfob_pkg.sv
// Shared types and constants for the one-bit frame store with rectangle fill.
// Command and response payload structs, opcodes, fill colors, controller states.
// No dependencies.
`default_nettype none

package rfob_pkg;

    localparam int LINES_DEF     = 64;
    localparam int ROW_BYTES_DEF = 50;

    // Row counter width: y + height never exceeds 63 + 127.
    localparam int ROW_W = 8;
    // Pixel column arithmetic width: holds ROW_BYTES * 8 up to 1024.
    localparam int XE_W  = 11;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FILL  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [1:0] COLOR_CLEAR  = 2'd0;
    localparam logic [1:0] COLOR_SET    = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    typedef struct packed {
        op_t        op;
        logic [8:0] x;
        logic [5:0] y;
        logic [8:0] width;
        logic [6:0] height;
        logic [1:0] color;
        logic [5:0] byte_col;
        logic [7:0] wdata;
    } cmd_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       is_read;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_FILL,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/rectangle_fill_one_bit_framebuffer.sv
// Top level: one-bit-per-pixel frame store with byte access and rectangle fill.
// Depends on rfob_pkg for payload structs, opcodes, colors and controller states.
`default_nettype none

// The store is one synchronous RAM of LINES x ROW_BYTES bytes, LSB = leftmost
// pixel, with no reset contents and no clearing pass: read only bytes you have
// written. A command transfer is taken only when the controller is idle; the
// response sits in an output register, so the next command can be taken while
// it waits. Byte write and no-op go from decode straight to the done state; byte
// read passes through a read state for the RAM output. A fill walks the clipped
// rectangle's rows and byte span, then drains the last write-back: the RAM's single read and
// write ports do one byte read-modify-write per cycle, reading the next byte
// while the previous one is written back. Empty or fully clipped fills go to done.
// The controller is idle again as the response is loaded, so the next command transfer can come in the cycle after.
module rectangle_fill_one_bit_framebuffer #(
    parameter int LINES     = rfob_pkg::LINES_DEF,
    parameter int ROW_BYTES = rfob_pkg::ROW_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire rfob_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output rfob_pkg::rsp_t      rsp
);
    import rfob_pkg::*;

    localparam int STORE_BYTES = LINES * ROW_BYTES;
    localparam int ROW_PIXELS  = ROW_BYTES * 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BC_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int PROD_W      = 14;

    // Frame store
    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        mem_q;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    // Control state
    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   wr_pend_reg, wr_pend_next;

    // Datapath registers
    cmd_t              cmd_reg;
    rsp_t              rsp_reg, rsp_next;
    logic [7:0]        res_rdata_reg, res_rdata_next;
    logic              res_is_read_reg, res_is_read_next;
    logic              inside_reg, inside_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  row_end_reg, row_end_next;
    logic [BC_W-1:0]   bcol_reg, bcol_next;
    logic [BC_W-1:0]   first_reg, first_next;
    logic [BC_W-1:0]   last_reg, last_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [7:0]        fmask_reg, fmask_next;
    logic [7:0]        lmask_reg, lmask_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]        wr_mask_reg, wr_mask_next;

    // Command decode, from the registered command
    logic              y_ok;
    logic              col_ok;
    logic [PROD_W-1:0] row_prod;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] byte_addr;
    logic [XE_W-1:0]   x_ext;
    logic [XE_W-1:0]   xsum;
    logic [XE_W-1:0]   xe;
    logic [XE_W-1:0]   xe_m1;
    logic [8:0]        ysum;
    logic [8:0]        ye;
    logic              fill_empty;
    logic [7:0]        cur_mask;
    logic [ADDR_W-1:0] fill_addr;
    logic              cmd_we;
    logic [7:0]        rop_byte;

    always_comb
    begin
        y_ok       = {3'b000, cmd_reg.y} < 9'(LINES);
        col_ok     = {2'b00, cmd_reg.byte_col} < 8'(ROW_BYTES);
        row_prod   = PROD_W'(cmd_reg.y) * PROD_W'(ROW_BYTES);
        row_base   = ADDR_W'(row_prod);
        byte_addr  = row_base + ADDR_W'(cmd_reg.byte_col);
        x_ext      = XE_W'(cmd_reg.x);
        xsum       = x_ext + XE_W'(cmd_reg.width);
        xe         = (xsum > XE_W'(ROW_PIXELS)) ? XE_W'(ROW_PIXELS) : xsum;
        xe_m1      = xe - XE_W'(1);
        ysum       = 9'(cmd_reg.y) + 9'(cmd_reg.height);
        ye         = (ysum > 9'(LINES)) ? 9'(LINES) : ysum;
        fill_empty = (cmd_reg.width == '0) || (cmd_reg.height == '0)
                     || (x_ext >= XE_W'(ROW_PIXELS)) || !y_ok;
    end

    // Mask of the byte issued this cycle: partial at the row ends
    always_comb
    begin
        cur_mask = 8'hFF;
        if (bcol_reg == first_reg)
            cur_mask = cur_mask & fmask_reg;
        if (bcol_reg == last_reg)
            cur_mask = cur_mask & lmask_reg;
        fill_addr = base_reg + ADDR_W'(bcol_reg);
    end

    // Raster op on the byte returned for the pending write
    always_comb
    begin
        case (cmd_reg.color)
            COLOR_CLEAR: rop_byte = mem_q & ~wr_mask_reg;
            COLOR_SET:   rop_byte = mem_q | wr_mask_reg;
            default:     rop_byte = mem_q ^ wr_mask_reg;
        endcase
    end

    // Write port: fill write-back has priority; it never overlaps a byte write
    always_comb
    begin
        cmd_we = (state_reg == ST_SETUP) && (cmd_reg.op == OP_WRITE) && y_ok && col_ok;
        mem_we = wr_pend_reg || cmd_we;
        mem_wa = wr_pend_reg ? wr_addr_reg : byte_addr;
        mem_wd = wr_pend_reg ? rop_byte : cmd_reg.wdata;
    end

    always_comb
    begin
        state_next       = state_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;
        wr_pend_next     = 1'b0;
        wr_addr_next     = wr_addr_reg;
        wr_mask_next     = wr_mask_reg;
        res_rdata_next   = res_rdata_reg;
        res_is_read_next = res_is_read_reg;
        inside_next      = inside_reg;
        row_next         = row_reg;
        row_end_next     = row_end_reg;
        bcol_next        = bcol_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        base_next        = base_reg;
        fmask_next       = fmask_reg;
        lmask_next       = lmask_reg;
        mem_re           = 1'b0;
        mem_ra           = fill_addr;
        cmd_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                res_rdata_next   = 8'h00;
                res_is_read_next = 1'b0;
                state_next       = ST_DONE;
                case (cmd_reg.op)
                    OP_READ:
                    begin
                        mem_re           = 1'b1;
                        mem_ra           = byte_addr;
                        inside_next      = y_ok && col_ok;
                        res_is_read_next = 1'b1;
                        state_next       = ST_READ;
                    end
                    OP_FILL:
                    begin
                        if (!fill_empty)
                        begin
                            row_next     = ROW_W'(cmd_reg.y);
                            row_end_next = ROW_W'(ye);
                            first_next   = BC_W'(cmd_reg.x >> 3);
                            bcol_next    = BC_W'(cmd_reg.x >> 3);
                            last_next    = BC_W'(xe_m1 >> 3);
                            base_next    = row_base;
                            fmask_next   = 8'hFF << cmd_reg.x[2:0];
                            lmask_next   = 8'hFF >> (3'd7 - xe_m1[2:0]);
                            state_next   = ST_FILL;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ:
            begin
                res_rdata_next = inside_reg ? mem_q : 8'h00;
                state_next     = ST_DONE;
            end
            ST_FILL:
            begin
                // Read this byte now, write it back next cycle
                mem_re       = 1'b1;
                mem_ra       = fill_addr;
                wr_pend_next = 1'b1;
                wr_addr_next = fill_addr;
                wr_mask_next = cur_mask;
                if (bcol_reg == last_reg)
                begin
                    bcol_next = first_reg;
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_reg + ADDR_W'(ROW_BYTES);
                    if ((row_reg + ROW_W'(1)) == row_end_reg)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    bcol_next = bcol_reg + BC_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.rdata   = res_rdata_reg;
                    rsp_next.is_read = res_is_read_reg;
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
        rsp_reg         <= rsp_next;
        res_rdata_reg   <= res_rdata_next;
        res_is_read_reg <= res_is_read_next;
        inside_reg      <= inside_next;
        row_reg         <= row_next;
        row_end_reg     <= row_end_next;
        bcol_reg        <= bcol_next;
        first_reg       <= first_next;
        last_reg        <= last_next;
        base_reg        <= base_next;
        fmask_reg       <= fmask_next;
        lmask_reg       <= lmask_next;
        wr_addr_reg     <= wr_addr_next;
        wr_mask_reg     <= wr_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // Fill write-back only follows a fill read
    a_wr_pend_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_FILL || state_reg == ST_DRAIN))
        else $error("write-back pending outside a fill");

    // Pipelined read-modify-write never reads the byte being written
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re && mem_we) |-> (mem_ra != mem_wa))
        else $error("read and write hit the same byte");

    // Byte column stays within the clipped span of the row
    a_bcol_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (bcol_reg >= first_reg && bcol_reg <= last_reg))
        else $error("fill byte column outside span");

    // A command transfer starts decode on the next cycle
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == ST_SETUP))
        else $error("command transfer did not start decode");

    // A response is only loaded after the controller finishes
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("response raised outside done state");
`endif

endmodule

`default_nettype wire

### dv/tb_rectangle_fill_one_bit_framebuffer.sv
// Self-checking testbench for the one-bit frame store with rectangle fill.
// Keeps a byte mirror of the frame store, predicts each response and checks it.
// Depends on rfob_pkg and the RTL top rectangle_fill_one_bit_framebuffer.
`default_nettype none

module tb_rectangle_fill_one_bit_framebuffer;

    import rfob_pkg::*;

    localparam int LINES       = LINES_DEF;
    localparam int ROW_BYTES   = ROW_BYTES_DEF;
    localparam int ROW_PIXELS  = ROW_BYTES * 8;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_SHOWN   = 10;

    // The package names colors 0..2 only; 3 behaves as invert.
    localparam logic [1:0] COLOR_ALT_INVERT = 2'd3;

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [7:0] frame_mirror [LINES * ROW_BYTES];
    rsp_t       rsp_owed [$];

    int fail_count  = 0;
    int cycle_count = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit hold_req    = 1'b0;

    rectangle_fill_one_bit_framebuffer #(
        .LINES     (LINES),
        .ROW_BYTES (ROW_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Applies one command to the mirror and returns the response it owes.
    function automatic rsp_t exec_on_frame(cmd_t c);
        rsp_t        r;
        int unsigned addr, x_end, y_end, b_lo, b_hi, x_last;
        logic [7:0]  m, lo_mask, hi_mask;
        r = '0;
        addr = int'(c.y) * ROW_BYTES + int'(c.byte_col);
        case (c.op)
            OP_WRITE:
            begin
                if (c.y < LINES && c.byte_col < ROW_BYTES)
                    frame_mirror[addr] = c.wdata;
            end
            OP_READ:
            begin
                r.is_read = 1'b1;
                if (c.y < LINES && c.byte_col < ROW_BYTES)
                    r.rdata = frame_mirror[addr];
            end
            OP_FILL:
            begin
                if (c.width != 0 && c.height != 0 && c.x < ROW_PIXELS && c.y < LINES)
                begin
                    x_end = int'(c.x) + int'(c.width);
                    if (x_end > ROW_PIXELS)
                        x_end = ROW_PIXELS;
                    y_end = int'(c.y) + int'(c.height);
                    if (y_end > LINES)
                        y_end = LINES;
                    x_last  = x_end - 1;
                    b_lo    = int'(c.x) / 8;
                    b_hi    = x_last / 8;
                    lo_mask = 8'hFF << c.x[2:0];
                    hi_mask = 8'hFF >> (7 - (x_last % 8));
                    for (int unsigned row = 32'(c.y); row < y_end; row++)
                    begin
                        for (int unsigned b = b_lo; b <= b_hi; b++)
                        begin
                            m = 8'hFF;
                            if (b == b_lo)
                                m &= lo_mask;
                            if (b == b_hi)
                                m &= hi_mask;
                            addr = row * ROW_BYTES + b;
                            case (c.color)
                                COLOR_CLEAR: frame_mirror[addr] &= ~m;
                                COLOR_SET:   frame_mirror[addr] |= m;
                                default:     frame_mirror[addr] ^= m;
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int unsigned idle_cycles();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic cmd_t noise_cmd();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return cmd_t'(bits[$bits(cmd_t)-1:0]);
    endfunction

    // One command transfer; valid stays up between back-to-back commands.
    task automatic send_cmd(input cmd_t c);
        int unsigned gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? idle_cycles() : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        rsp_owed.push_back(exec_on_frame(c));
    endtask

    task automatic do_byte(input op_t op, input logic [5:0] y, input logic [5:0] col,
                           input logic [7:0] wdata);
        cmd_t c;
        c          = noise_cmd();
        c.op       = op;
        c.y        = y;
        c.byte_col = col;
        c.wdata    = wdata;
        send_cmd(c);
    endtask

    task automatic do_fill(input logic [8:0] x, input logic [5:0] y, input logic [8:0] w,
                           input logic [6:0] h, input logic [1:0] color);
        cmd_t c;
        c        = noise_cmd();
        c.op     = OP_FILL;
        c.x      = x;
        c.y      = y;
        c.width  = w;
        c.height = h;
        c.color  = color;
        send_cmd(c);
    endtask

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_owed.size() == 0)
                note_fail($sformatf("response with none outstanding: rdata=%02h is_read=%b",
                                    rsp.rdata, rsp.is_read));
            else
            begin
                want = rsp_owed.pop_front();
                if (rsp.rdata !== want.rdata)
                    note_fail($sformatf("rdata expected %02h, got %02h", want.rdata, rsp.rdata));
                if (rsp.is_read !== want.is_read)
                    note_fail($sformatf("is_read expected %b, got %b",
                                        want.is_read, rsp.is_read));
            end
        end
    end

    // Response side: random stalls, plus a long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 30)
            begin
                rsp_ready <= 1'b0;
                repeat (idle_cycles()) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Full-byte clear over the whole store gives every byte a known value.
    task automatic test_clear_store();
        do_fill(9'd0, 6'd0, 9'd511, 7'd127, COLOR_CLEAR);
    endtask

    task automatic test_byte_access();
        do_byte(OP_WRITE, 6'd0, 6'd0, 8'hA5);
        do_byte(OP_WRITE, 6'd63, 6'd49, 8'hFF);
        do_byte(OP_WRITE, 6'd5, 6'd63, 8'h00);     // column past the row: dropped
        do_byte(OP_READ, 6'd0, 6'd0, 8'h00);
        do_byte(OP_READ, 6'd63, 6'd49, 8'h00);
        do_byte(OP_READ, 6'd5, 6'd63, 8'hFF);
        do_byte(OP_NOP, 6'd7, 6'd3, 8'h5A);
    endtask

    task automatic test_fill_shapes();
        do_fill(9'd3, 6'd1, 9'd1, 7'd1, COLOR_SET);
        do_fill(9'd9, 6'd1, 9'd5, 7'd2, COLOR_SET);
        do_fill(9'd5, 6'd2, 9'd20, 7'd3, COLOR_INVERT);
        do_fill(9'd0, 6'd1, 9'd16, 7'd1, COLOR_ALT_INVERT);
        do_fill(9'd0, 6'd0, 9'd0, 7'd5, COLOR_SET);          // empty width
        do_fill(9'd0, 6'd0, 9'd8, 7'd0, COLOR_SET);          // empty height
        do_fill(9'd400, 6'd0, 9'd8, 7'd1, COLOR_SET);        // starts past right edge
        do_fill(9'd511, 6'd63, 9'd511, 7'd127, COLOR_SET);
        do_fill(9'd390, 6'd60, 9'd511, 7'd127, COLOR_INVERT); // clipped right and bottom
        do_fill(9'd8, 6'd3, 9'd8, 7'd1, COLOR_SET);          // one aligned byte
        do_byte(OP_READ, 6'd1, 6'd0, 8'h00);
        do_byte(OP_READ, 6'd1, 6'd1, 8'h00);
        do_byte(OP_READ, 6'd2, 6'd3, 8'h00);
        do_byte(OP_READ, 6'd3, 6'd1, 8'h00);
        do_byte(OP_READ, 6'd60, 6'd49, 8'h00);
        do_byte(OP_READ, 6'd63, 6'd48, 8'h00);
    endtask

    task automatic test_random_traffic(input int count);
        cmd_t        c;
        cmd_t        recent;
        int unsigned pick;
        recent = '0;
        repeat (count)
        begin
            c    = noise_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                c.op = OP_WRITE;
                if ($urandom_range(0, 9) != 0)
                    c.byte_col = 6'($urandom_range(0, ROW_BYTES - 1));
            end
            else if (pick < 65)
            begin
                c.op = OP_READ;
                // Half the reads look at the last rectangle.
                if ($urandom_range(0, 1) == 0)
                begin
                    c.y        = recent.y + 6'($urandom_range(0, 3));
                    c.byte_col = 6'(recent.x / 8) + 6'($urandom_range(0, 2));
                end
                else if ($urandom_range(0, 9) != 0)
                    c.byte_col = 6'($urandom_range(0, ROW_BYTES - 1));
            end
            else if (pick < 95)
            begin
                c.op = OP_FILL;
                // Most rectangles stay small; a few keep a random position and size.
                if ($urandom_range(0, 19) != 0)
                begin
                    c.x      = 9'($urandom_range(0, ROW_PIXELS - 1));
                    c.width  = 9'($urandom_range(0, 40));
                    c.height = 7'($urandom_range(0, 6));
                end
                recent = c;
            end
            else
                c.op = OP_NOP;
            send_cmd(c);
        end
    endtask

    // Receiver holds off while commands keep coming, so the block backs up.
    task automatic test_output_backpressure();
        bit saved_tx;
        saved_tx   = tx_idle_on;
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        test_random_traffic(10);
        tx_idle_on = saved_tx;
        if (hold_req)
        begin
            // Last command is taken; drop valid while the hold-off runs out.
            cmd_valid <= 1'b0;
            wait (!hold_req);
            @(posedge clk);
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_clear_store();
        test_byte_access();
        test_fill_shapes();
        test_random_traffic(86);
        test_output_backpressure();
        test_back_to_back();
        test_random_traffic(20);

        cmd_valid <= 1'b0;
        while (rsp_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
